/* sv/scs_pkg.sv */
package scs_pkg;

  localparam int VAL_W    = 48;
  localparam int JOINT_W  = 5;
  localparam int LOCAL_W  = 3;
  localparam int GIDX_W   = 7;
  localparam int CFG_W    = 6;
  localparam int STATUS_W = 2;

  localparam int JOINTS_RESET = 32;

  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SAT   = 2'd2;

  typedef logic signed [VAL_W-1:0] value_t;
  typedef logic [STATUS_W-1:0]     status_t;

endpackage

/* sv/scs_if.sv */
interface scs_cmd_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [scs_pkg::JOINT_W-1:0]   joint_a;
  logic [scs_pkg::JOINT_W-1:0]   joint_b;
  logic [scs_pkg::LOCAL_W-1:0]   local_row;
  logic [scs_pkg::LOCAL_W-1:0]   local_col;
  scs_pkg::value_t               entry_value;
  logic [scs_pkg::GIDX_W-1:0]    global_row;
  logic [scs_pkg::GIDX_W-1:0]    global_col;

  modport source (output valid, action, joint_a, joint_b, local_row, local_col,
                  entry_value, global_row, global_col, input ready);
  modport sink   (input valid, action, joint_a, joint_b, local_row, local_col,
                  entry_value, global_row, global_col, output ready);
endinterface

interface scs_res_if;
  logic              valid;
  logic              ready;
  scs_pkg::value_t   read_value;
  scs_pkg::status_t  status;

  modport source (output valid, read_value, status, input ready);
  modport sink   (input valid, read_value, status, output ready);
endinterface

/* sv/scs_front.sv */
module scs_front #(
  parameter int  DOF_PER_JOINT = 3,
  parameter int  MAX_JOINTS    = 32,
  parameter type item_t        = logic
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_en,
  input  logic [scs_pkg::CFG_W-1:0] wr_data,
  scs_cmd_if.sink    cmd,
  input  logic       clearing,
  input  logic       q_ready,
  output logic       push,
  output item_t      item
);

  localparam int SIDE = DOF_PER_JOINT * MAX_JOINTS;
  localparam int RW   = $clog2(SIDE);
  localparam int NW   = $clog2(MAX_JOINTS + 1);
  localparam int CW   = (NW > scs_pkg::CFG_W) ? NW : scs_pkg::CFG_W;
  localparam int LW   = $clog2(SIDE + 1);
  localparam int GW   = (LW > scs_pkg::GIDX_W) ? LW : scs_pkg::GIDX_W;
  localparam int XW   = scs_pkg::LOCAL_W + 1;
  localparam int JRST = (scs_pkg::JOINTS_RESET > MAX_JOINTS) ? MAX_JOINTS
                                                              : scs_pkg::JOINTS_RESET;

  // effective joint count and matching row limit, kept ready for compares
  logic [NW-1:0] jcount;
  logic [NW-1:0] jcount_next;
  logic [LW-1:0] row_lim;
  logic [LW-1:0] row_lim_next;
  logic [CW-1:0] wr_ext;

  logic joint_bad;
  logic local_bad;
  logic read_bad;

  function automatic logic [RW-1:0] map_local(input logic [scs_pkg::LOCAL_W-1:0] l,
                                               input logic [scs_pkg::JOINT_W-1:0] ja,
                                               input logic [scs_pkg::JOINT_W-1:0] jb);
    if (XW'(l) < XW'(DOF_PER_JOINT)) begin
      return RW'(ja) * RW'(DOF_PER_JOINT) + RW'(l);
    end
    return RW'(jb) * RW'(DOF_PER_JOINT) + RW'(l) - RW'(DOF_PER_JOINT);
  endfunction

  always_comb begin
    wr_ext       = CW'(wr_data);
    jcount_next  = (wr_ext > CW'(MAX_JOINTS)) ? NW'(MAX_JOINTS) : NW'(wr_ext);
    row_lim_next = LW'(jcount_next) * LW'(DOF_PER_JOINT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      jcount  <= NW'(JRST);
      row_lim <= LW'(JRST * DOF_PER_JOINT);
    end else if (wr_en) begin
      jcount  <= jcount_next;
      row_lim <= row_lim_next;
    end
  end

  always_comb begin
    joint_bad = (CW'(cmd.joint_a) >= CW'(jcount)) || (CW'(cmd.joint_b) >= CW'(jcount));
    local_bad = (XW'(cmd.local_row) >= XW'(2 * DOF_PER_JOINT)) ||
                (XW'(cmd.local_col) >= XW'(2 * DOF_PER_JOINT));
    read_bad  = (GW'(cmd.global_row) >= GW'(row_lim)) ||
                (GW'(cmd.global_col) >= GW'(row_lim));

    item.act   = cmd.action;
    item.value = cmd.entry_value;
    if (cmd.action == scs_pkg::ACT_ADD) begin
      item.err = joint_bad || local_bad;
      item.row = map_local(cmd.local_row, cmd.joint_a, cmd.joint_b);
      item.col = map_local(cmd.local_col, cmd.joint_a, cmd.joint_b);
    end else begin
      item.err = read_bad;
      item.row = RW'(cmd.global_row);
      item.col = RW'(cmd.global_col);
    end
  end

  assign cmd.ready = q_ready && !clearing;
  assign push      = cmd.valid && cmd.ready;

endmodule

/* sv/scs_queue.sv */
module scs_queue #(
  parameter type item_t = logic
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  ready,
  output logic  valid,
  input  logic  pop,
  output item_t head
);

  item_t      slot [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;

  assign ready = (count != 2'd2);
  assign valid = (count != 2'd0);
  assign head  = slot[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wp] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* sv/scs_back.sv */
module scs_back #(
  parameter int  DOF_PER_JOINT = 3,
  parameter int  MAX_JOINTS    = 32,
  parameter type item_t        = logic
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  item_t      head,
  output logic       pop,
  output logic       clearing,
  scs_res_if.source  res
);

  localparam int SIDE  = DOF_PER_JOINT * MAX_JOINTS;
  localparam int DEPTH = SIDE * SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int VW    = scs_pkg::VAL_W;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_DATA  = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [AW-1:0]    clr_addr;

  logic [VW-1:0]    mem [DEPTH];
  logic [VW-1:0]    mem_q;
  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  logic [VW-1:0]    mem_wd;
  logic [AW-1:0]    rd_addr;

  logic             op_act;
  logic [AW-1:0]    op_addr;
  scs_pkg::value_t  op_value;

  logic [VW:0]      sum;
  logic             sat_hi;
  logic             sat_lo;

  logic             res_free;
  logic             load;
  scs_pkg::value_t  load_value;
  scs_pkg::status_t load_status;

  logic             out_valid;
  scs_pkg::value_t  out_value;
  scs_pkg::status_t out_status;

  assign rd_addr  = AW'(head.row) * AW'(SIDE) + AW'(head.col);
  assign res_free = !out_valid || res.ready;
  assign clearing = (state == S_CLEAR);

  // one extra bit catches overflow; top two bits disagree on overflow
  assign sum    = {mem_q[VW-1], mem_q} + {op_value[VW-1], op_value};
  assign sat_hi = !sum[VW] && sum[VW-1];
  assign sat_lo = sum[VW] && !sum[VW-1];

  always_comb begin
    state_next  = state;
    pop         = 1'b0;
    mem_we      = 1'b0;
    mem_wa      = clr_addr;
    mem_wd      = '0;
    load        = 1'b0;
    load_value  = '0;
    load_status = scs_pkg::ST_OK;
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid && res_free) begin
          pop = 1'b1;
          if (head.err) begin
            load        = 1'b1;
            load_status = scs_pkg::ST_RANGE;
          end else begin
            state_next = S_DATA;
          end
        end
      end
      S_DATA: begin
        load       = 1'b1;
        state_next = S_IDLE;
        if (op_act == scs_pkg::ACT_READ) begin
          load_value = mem_q;
        end else begin
          mem_we = 1'b1;
          mem_wa = op_addr;
          if (sat_hi) begin
            mem_wd      = {1'b0, {(VW-1){1'b1}}};
            load_status = scs_pkg::ST_SAT;
          end else if (sat_lo) begin
            mem_wd      = {1'b1, {(VW-1){1'b0}}};
            load_status = scs_pkg::ST_SAT;
          end else begin
            mem_wd = sum[VW-1:0];
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      op_act   <= head.act;
      op_addr  <= rd_addr;
      op_value <= head.value;
    end
    if (load) begin
      out_value  <= load_value;
      out_status <= load_status;
    end
  end

  assign res.valid      = out_valid;
  assign res.read_value = out_value;
  assign res.status     = out_status;

endmodule

/* sv/stiffness_scatter_accumulate.sv */
// Global stiffness assembly for two-joint elements. Each cmd word either adds one
// element-matrix entry (in local coordinates, mapped via joint_a/joint_b) into the
// global matrix, with saturation, or reads one global entry back; every cmd word
// yields exactly one res word, in order. After reset the matrix memory is zeroed by
// a clearing pass over all (DOF_PER_JOINT*MAX_JOINTS)^2 entries (9216 at defaults),
// during which cmd.ready stays low; wr_en/wr_data writes of the joint count are
// taken at any time. A valid add or read does a registered read of the matrix
// memory, then add/saturate/write-back; a rejected word is answered from the idle
// state without that memory step. A 2-word queue between the classifying front end
// and the back end takes up to two more cmd words while a result waits for res.ready.
module stiffness_scatter_accumulate #(
  parameter int DOF_PER_JOINT = 3,
  parameter int MAX_JOINTS    = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [scs_pkg::CFG_W-1:0] wr_data,
  scs_cmd_if.sink                   cmd,
  scs_res_if.source                 res
);

  localparam int SIDE = DOF_PER_JOINT * MAX_JOINTS;
  localparam int RW   = $clog2(SIDE);

  typedef struct packed {
    logic            act;
    logic            err;
    logic [RW-1:0]   row;
    logic [RW-1:0]   col;
    scs_pkg::value_t value;
  } item_t;

  logic  push;
  item_t push_item;
  logic  q_ready;
  logic  q_valid;
  logic  pop;
  item_t head;
  logic  clearing;

  scs_front #(
    .DOF_PER_JOINT (DOF_PER_JOINT),
    .MAX_JOINTS    (MAX_JOINTS),
    .item_t        (item_t)
  ) front_i (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_data  (wr_data),
    .cmd      (cmd),
    .clearing (clearing),
    .q_ready  (q_ready),
    .push     (push),
    .item     (push_item)
  );

  scs_queue #(
    .item_t (item_t)
  ) queue_i (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .ready     (q_ready),
    .valid     (q_valid),
    .pop       (pop),
    .head      (head)
  );

  scs_back #(
    .DOF_PER_JOINT (DOF_PER_JOINT),
    .MAX_JOINTS    (MAX_JOINTS),
    .item_t        (item_t)
  ) back_i (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .head     (head),
    .pop      (pop),
    .clearing (clearing),
    .res      (res)
  );

endmodule

/* sv/scs_checker.sv */
module scs_checker (
  input logic             clk,
  input logic             rst,
  input logic             cmd_ready,
  input logic             res_valid,
  input logic             res_ready,
  input scs_pkg::value_t  read_value,
  input scs_pkg::status_t status
);

  // clearing pass follows every reset
  a_clear_after_reset: assert property (@(posedge clk) $past(rst) |-> !cmd_ready)
    else $error("cmd accepted right after reset");

  a_no_res_after_reset: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("res word present right after reset");

  a_err_zero_value: assert property (@(posedge clk) disable iff (rst)
      res_valid && status != scs_pkg::ST_OK |-> read_value == '0)
    else $error("nonzero read_value on rejected or saturated word");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
      res_valid && !res_ready |=> res_valid && $stable(read_value) && $stable(status))
    else $error("res word changed while stalled");

endmodule

bind stiffness_scatter_accumulate scs_checker checker_i (
  .clk        (clk),
  .rst        (rst),
  .cmd_ready  (cmd.ready),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .read_value (res.read_value),
  .status     (res.status)
);
